### rtl/core/acu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acu_pkg
// Shared types and constants for the accumulator CPU execute unit.
// ----------------------------------------------------------------------------
package acu_pkg;

  // Mnemonic codes, alphabetical order.
  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
    OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
    OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
    OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
    OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
    OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
    OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
    OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
    OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35,
    OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
    OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43,
    OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47,
    OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51,
    OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55
  } op_t;

  // Status bit positions.
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_I = 2;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_N = 7;

  localparam logic [7:0]  PUSH_BITS = 8'h30;
  localparam logic [7:0]  PULL_MASK = 8'hCF;
  localparam logic [7:0]  SP_RESET  = 8'hFF;

  // Register index of the break vector.
  localparam logic REG_BRK_VEC = 1'b0;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_PUSH = 3'b010,
    S_PULL = 3'b100
  } state_t;

endpackage

### rtl/core/accumulator_cpu_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_unit
// Executes one decoded 8-bit accumulator CPU instruction per input beat and
// keeps the registers, flags and a 256-byte stack.
// ----------------------------------------------------------------------------
// Timing: result beat in the cycle after accept for most opcodes; JSR,
// PLA/PLP, BRK, RTS and RTI first push or pull, one stack access per step.
// Throughput: one beat per cycle for the rest while out_stall is low.
// Reset: A, X, Y, PC, flags and break vector clear, SP becomes 0xFF, and the
// stack reads as zero through per-entry valid bits; no clearing pass.
module accumulator_cpu_execute_unit
  import acu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  op,
  input  logic [7:0]  operand,
  input  logic [15:0] target_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        store_enable,
  output logic [7:0]  store_value,
  output logic [7:0]  acc_out,
  output logic [7:0]  x_out,
  output logic [7:0]  y_out,
  output logic [7:0]  sp_out,
  output logic [7:0]  flags_out,
  output logic [15:0] pc_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Architectural state.
  logic [7:0]  acc, idx_x, idx_y, sp, flags;
  logic [15:0] pc;
  logic [15:0] break_vector;
  state_t      state;
  logic [1:0]  seq_cnt;
  logic [7:0]  pend0, pend1, pull_lo;
  logic [5:0]  seq_op;

  // Stack memory with registered read.
  logic [7:0]  stack_mem [256];
  logic [255:0] stack_vld;
  logic [7:0]  rd_data;
  logic        rd_hit;
  logic        mem_we, mem_re;
  logic [7:0]  mem_wa, mem_wd, mem_ra;
  logic [7:0]  pull_byte;

  // Single-pass execution results.
  logic [7:0]  e_a, e_x, e_y, e_sp, e_p, e_sv, e_pd, e_m;
  logic [15:0] e_pc, e_w;
  logic        e_st, e_push;
  logic [1:0]  e_rest, e_npull;
  logic [8:0]  e_sum;
  logic [7:0]  cmp_reg, cmp_diff, e_r;

  // Next values and control.
  logic        accept, out_free, step, emit;
  logic [7:0]  n_a, n_x, n_y, n_sp, n_p, n_sv;
  logic [15:0] n_pc;
  logic        n_st;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_RUN) && out_free);
  assign pull_byte = rd_hit ? rd_data : 8'd0;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BRK_VEC) ? {16'd0, break_vector} : 32'd0;

  // Instruction execution from the input beat and current registers.
  always_comb begin
    e_a = acc;  e_x = idx_x;  e_y = idx_y;  e_sp = sp;  e_p = flags;  e_pc = pc;
    e_st = 1'b0;  e_sv = 8'd0;  e_push = 1'b0;  e_pd = 8'd0;
    e_rest = 2'd0;  e_npull = 2'd0;  e_w = 16'd0;
    e_m = (op == OP_SBC) ? ~operand : operand;
    e_sum = {1'b0, acc} + {1'b0, e_m} + {8'd0, flags[FL_C]};
    e_r = e_sum[7:0];
    cmp_reg = (op == OP_CPX) ? idx_x : ((op == OP_CPY) ? idx_y : acc);
    cmp_diff = cmp_reg - operand;
    case (op)
      OP_ADC, OP_SBC: begin
        e_a = e_r;
        e_p[FL_C] = e_sum[8];
        e_p[FL_V] = (~(acc[7] ^ e_m[7])) & (acc[7] ^ e_r[7]);
      end
      OP_AND: e_a = acc & operand;
      OP_EOR: e_a = acc ^ operand;
      OP_ORA: e_a = acc | operand;
      OP_ASL: begin
        e_p[FL_C] = operand[7];  e_sv = {operand[6:0], 1'b0};  e_st = 1'b1;
      end
      OP_LSR: begin
        e_p[FL_C] = operand[0];  e_sv = {1'b0, operand[7:1]};  e_st = 1'b1;
      end
      OP_ROL: begin
        e_p[FL_C] = operand[7];  e_sv = {operand[6:0], flags[FL_C]};  e_st = 1'b1;
      end
      OP_ROR: begin
        e_p[FL_C] = operand[0];  e_sv = {flags[FL_C], operand[7:1]};  e_st = 1'b1;
      end
      OP_BCC: if (!flags[FL_C]) e_pc = pc + {{8{operand[7]}}, operand};
      OP_BCS: if (flags[FL_C])  e_pc = pc + {{8{operand[7]}}, operand};
      OP_BEQ: if (flags[FL_Z])  e_pc = pc + {{8{operand[7]}}, operand};
      OP_BNE: if (!flags[FL_Z]) e_pc = pc + {{8{operand[7]}}, operand};
      OP_BMI: if (flags[FL_N])  e_pc = pc + {{8{operand[7]}}, operand};
      OP_BPL: if (!flags[FL_N]) e_pc = pc + {{8{operand[7]}}, operand};
      OP_BVC: if (!flags[FL_V]) e_pc = pc + {{8{operand[7]}}, operand};
      OP_BVS: if (flags[FL_V])  e_pc = pc + {{8{operand[7]}}, operand};
      OP_BIT: begin
        e_p[FL_Z] = ((acc & operand) == 8'd0);
        e_p[FL_V] = operand[6];
        e_p[FL_N] = operand[7];
      end
      OP_BRK: begin
        e_w = pc + 16'd1;
        e_push = 1'b1;  e_pd = e_w[15:8];  e_sp = sp - 8'd1;  e_rest = 2'd2;
        e_pc = break_vector;
        e_p[FL_I] = 1'b1;
      end
      OP_CLC: e_p[FL_C] = 1'b0;
      OP_CLD: e_p[FL_D] = 1'b0;
      OP_CLI: e_p[FL_I] = 1'b0;
      OP_CLV: e_p[FL_V] = 1'b0;
      OP_SEC: e_p[FL_C] = 1'b1;
      OP_SED: e_p[FL_D] = 1'b1;
      OP_SEI: e_p[FL_I] = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        e_p[FL_C] = (cmp_reg >= operand);
        e_p[FL_Z] = (cmp_reg == operand);
        e_p[FL_N] = cmp_diff[7];
      end
      OP_DEC: begin e_sv = operand - 8'd1;  e_st = 1'b1; end
      OP_INC: begin e_sv = operand + 8'd1;  e_st = 1'b1; end
      OP_DEX: e_x = idx_x - 8'd1;
      OP_DEY: e_y = idx_y - 8'd1;
      OP_INX: e_x = idx_x + 8'd1;
      OP_INY: e_y = idx_y + 8'd1;
      OP_JMP: e_pc = target_address;
      OP_JSR: begin
        e_w = pc - 16'd1;
        e_push = 1'b1;  e_pd = e_w[15:8];  e_sp = sp - 8'd1;  e_rest = 2'd1;
        e_pc = target_address;
      end
      OP_LDA: e_a = operand;
      OP_LDX: e_x = operand;
      OP_LDY: e_y = operand;
      OP_PHA: begin e_push = 1'b1;  e_pd = acc;  e_sp = sp - 8'd1; end
      OP_PHP: begin e_push = 1'b1;  e_pd = flags | PUSH_BITS;  e_sp = sp - 8'd1; end
      OP_PLA, OP_PLP: begin e_npull = 2'd1;  e_sp = sp + 8'd1; end
      OP_RTS: begin e_npull = 2'd2;  e_sp = sp + 8'd1; end
      OP_RTI: begin e_npull = 2'd3;  e_sp = sp + 8'd1; end
      OP_STA: begin e_sv = acc;    e_st = 1'b1; end
      OP_STX: begin e_sv = idx_x;  e_st = 1'b1; end
      OP_STY: begin e_sv = idx_y;  e_st = 1'b1; end
      OP_TAX: e_x = acc;
      OP_TAY: e_y = acc;
      OP_TSX: e_x = sp;
      OP_TXA: e_a = idx_x;
      OP_TXS: e_sp = idx_x;
      OP_TYA: e_a = idx_y;
      default: ;
    endcase
    // Zero and negative flags from the result that each group produces.
    case (op)
      OP_ADC, OP_SBC, OP_AND, OP_EOR, OP_ORA, OP_LDA, OP_TXA, OP_TYA: begin
        e_p[FL_Z] = (e_a == 8'd0);  e_p[FL_N] = e_a[7];
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_DEC, OP_INC: begin
        e_p[FL_Z] = (e_sv == 8'd0);  e_p[FL_N] = e_sv[7];
      end
      OP_DEX, OP_INX, OP_LDX, OP_TAX, OP_TSX: begin
        e_p[FL_Z] = (e_x == 8'd0);  e_p[FL_N] = e_x[7];
      end
      OP_DEY, OP_INY, OP_LDY, OP_TAY: begin
        e_p[FL_Z] = (e_y == 8'd0);  e_p[FL_N] = e_y[7];
      end
      default: ;
    endcase
  end

  // Sequencer step, next register values and stack port control.
  always_comb begin
    n_a = acc;  n_x = idx_x;  n_y = idx_y;  n_sp = sp;  n_p = flags;  n_pc = pc;
    n_st = 1'b0;  n_sv = 8'd0;
    step = 1'b0;  emit = 1'b0;
    mem_we = 1'b0;  mem_wa = sp;  mem_wd = pend0;
    mem_re = 1'b0;  mem_ra = sp + 8'd1;
    unique case (state)
      S_RUN: begin
        step = accept;
        emit = accept && (e_rest == 2'd0) && (e_npull == 2'd0);
        n_a = e_a;  n_x = e_x;  n_y = e_y;  n_sp = e_sp;  n_p = e_p;  n_pc = e_pc;
        n_st = e_st;  n_sv = e_sv;
        mem_we = accept && e_push;
        mem_wd = e_pd;
        mem_re = accept && (e_npull != 2'd0);
      end
      S_PUSH: begin
        step = (seq_cnt != 2'd1) || out_free;
        emit = step && (seq_cnt == 2'd1);
        n_sp = sp - 8'd1;
        mem_we = step;
      end
      S_PULL: begin
        step = (seq_cnt != 2'd1) || out_free;
        emit = step && (seq_cnt == 2'd1);
        mem_re = step && (seq_cnt != 2'd1);
        if (seq_cnt != 2'd1) begin
          n_sp = sp + 8'd1;
          if (seq_cnt == 2'd3) n_p = pull_byte & PULL_MASK;
        end else begin
          case (seq_op)
            OP_PLA: begin
              n_a = pull_byte;
              n_p[FL_Z] = (pull_byte == 8'd0);
              n_p[FL_N] = pull_byte[7];
            end
            OP_PLP:  n_p = pull_byte & PULL_MASK;
            OP_RTS:  n_pc = {pull_byte, pull_lo} + 16'd1;
            default: n_pc = {pull_byte, pull_lo};
          endcase
        end
      end
      default: ;
    endcase
  end

  // Registers, sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'd0;  idx_x <= 8'd0;  idx_y <= 8'd0;  sp <= SP_RESET;
      flags <= 8'd0;  pc <= 16'd0;  break_vector <= 16'd0;
      state <= S_RUN;  seq_cnt <= 2'd0;  out_valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == REG_BRK_VEC)) begin
        break_vector <= pwdata[15:0];
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        acc <= n_a;  idx_x <= n_x;  idx_y <= n_y;  sp <= n_sp;
        flags <= n_p;  pc <= n_pc;
      end
      unique case (state)
        S_RUN: begin
          if (accept && (e_rest != 2'd0)) begin
            state <= S_PUSH;  seq_cnt <= e_rest;
          end else if (accept && (e_npull != 2'd0)) begin
            state <= S_PULL;  seq_cnt <= e_npull;
          end
        end
        S_PUSH, S_PULL: begin
          if (step) begin
            seq_cnt <= seq_cnt - 2'd1;
            if (seq_cnt == 2'd1) state <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

  // Sequence payload and result fields.
  always_ff @(posedge clk) begin
    if (state == S_RUN && accept) begin
      seq_op <= op;
      pend0  <= e_w[7:0];
      pend1  <= flags | PUSH_BITS;
    end else if (state == S_PUSH && step) begin
      pend0 <= pend1;
    end
    if (state == S_PULL && step && seq_cnt == 2'd2) pull_lo <= pull_byte;
    if (emit) begin
      store_enable <= n_st;
      store_value  <= n_sv;
      acc_out      <= n_a;
      x_out        <= n_x;
      y_out        <= n_y;
      sp_out       <= n_sp;
      flags_out    <= n_p;
      pc_out       <= n_pc;
    end
  end

  // Stack array with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= stack_mem[mem_ra];
  end

  // Per-entry valid bits; an unwritten entry reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_vld <= '0;
      rd_hit    <= 1'b0;
    end else begin
      if (mem_we) stack_vld[mem_wa] <= 1'b1;
      if (mem_re) rd_hit <= stack_vld[mem_ra];
    end
  end

`ifndef SYNTHESIS
  // A one-byte push lowers the stack pointer by one.
  a_pha_sp: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_PHA) |=> (sp == $past(sp) - 8'd1))
    else $error("PHA did not decrement SP");

  // A multi-cycle sequence always has work left.
  a_seq_cnt: assert property (@(posedge clk) disable iff (rst)
    (state != S_RUN) |-> (seq_cnt != 2'd0))
    else $error("sequencer busy with zero count");

  // JSR enters the push sequence for its low byte.
  a_jsr_push: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_JSR) |=> (state == S_PUSH && seq_cnt == 2'd1))
    else $error("JSR did not start push sequence");
`endif

endmodule
